// ===== rtl/cartesian_to_polar_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cartesian_to_polar block
// Clocked on clk_i, held off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_ASSERT_SVH
`define CARTESIAN_TO_POLAR_ASSERT_SVH

// property must hold at every edge out of reset
`define CP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true out of reset
`define CP_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

// ===== rtl/cp_pkg.sv =====
// ----------------------------------------------------------------------------
// cp_pkg
// Shared types, constants and the arctangent table of the polar converter.
// ----------------------------------------------------------------------------
package cp_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned ANGLE_WIDTH_DEF = 16;
  localparam int unsigned ITERATIONS_DEF  = 16;

  // angle accumulator: signed count of 2^-32 turn
  localparam int unsigned ACC_W = 32;
  // fractional bits given to the rotated coordinates
  localparam int unsigned COORD_FRAC = 16;
  // integer headroom for the CORDIC gain and the sign
  localparam int unsigned CORDIC_HEADROOM = 3;
  localparam int unsigned FIFO_DEPTH = 4;

  localparam logic [ACC_W-1:0] HALF_TURN = 32'h8000_0000;
  localparam logic signed [ACC_W-1:0] QUARTER_M1     = 32'sh3FFF_FFFF;
  localparam logic signed [ACC_W-1:0] NEG_QUARTER_M1 = -32'sh3FFF_FFFF;
  localparam logic signed [ACC_W-1:0] ACC_MINUS_ONE  = -32'sh1;

  // quadrant codes for results that sit exactly on an axis
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic       special;  // axis or origin, angle is quad * quarter turn
    logic [1:0] quad;
    logic       base;     // point was turned by half a turn
    logic       upper;    // rotated y is positive
  } cp_ctl_t;

  // round(atan(2^-i) * 2^32 / 2pi)
  function automatic logic [ACC_W-1:0] cp_atan(input int unsigned i);
    logic [ACC_W-1:0] r;
    unique case (i)
      0:  r = 32'h2000_0000;
      1:  r = 32'h12E4_051E;
      2:  r = 32'h09FB_385B;
      3:  r = 32'h0511_11D4;
      4:  r = 32'h028B_0D43;
      5:  r = 32'h0145_D7E1;
      6:  r = 32'h00A2_F61E;
      7:  r = 32'h0051_7C55;
      8:  r = 32'h0028_BE53;
      9:  r = 32'h0014_5F2F;
      10: r = 32'h000A_2F98;
      11: r = 32'h0005_17CC;
      12: r = 32'h0002_8BE6;
      13: r = 32'h0001_45F3;
      14: r = 32'h0000_A2FA;
      15: r = 32'h0000_517D;
      16: r = 32'h0000_28BE;
      17: r = 32'h0000_145F;
      18: r = 32'h0000_0A30;
      19: r = 32'h0000_0518;
      20: r = 32'h0000_028C;
      21: r = 32'h0000_0146;
      22: r = 32'h0000_00A3;
      23: r = 32'h0000_0051;
      24: r = 32'h0000_0029;
      25: r = 32'h0000_0014;
      26: r = 32'h0000_000A;
      27: r = 32'h0000_0005;
      28: r = 32'h0000_0003;
      29: r = 32'h0000_0001;
      30: r = 32'h0000_0001;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/cp_front.sv =====
// ----------------------------------------------------------------------------
// cp_front
// Classifies a point (origin, axis, general), turns left-half-plane points
// by half a turn and forms the squares of |x| and |y|.
// ----------------------------------------------------------------------------
module cp_front import cp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic signed [COORD_WIDTH-1:0]   coord_x_i,
  input  logic signed [COORD_WIDTH-1:0]   coord_y_i,
  output cp_ctl_t                         ctl_o,
  output logic signed [COORD_WIDTH:0]     px_o,
  output logic signed [COORD_WIDTH:0]     py_o,
  output logic [2*COORD_WIDTH-1:0]        sq_x_o,
  output logic [2*COORD_WIDTH-1:0]        sq_y_o
);

  localparam int unsigned SQ_W = 2 * COORD_WIDTH;

  logic signed [COORD_WIDTH:0] x_ext, y_ext, x_neg, y_neg, px_rot, py_rot;
  logic [COORD_WIDTH-1:0]      ax, ay;
  logic                        x_zero, y_zero, x_sgn, y_sgn;

  assign x_sgn  = coord_x_i[COORD_WIDTH-1];
  assign y_sgn  = coord_y_i[COORD_WIDTH-1];
  assign x_ext  = {x_sgn, coord_x_i};
  assign y_ext  = {y_sgn, coord_y_i};
  assign x_neg  = -x_ext;
  assign y_neg  = -y_ext;
  assign x_zero = (coord_x_i == '0);
  assign y_zero = (coord_y_i == '0);

  // most negative input: the negated value still fits the low bits unsigned
  assign ax = x_sgn ? x_neg[COORD_WIDTH-1:0] : coord_x_i[COORD_WIDTH-1:0];
  assign ay = y_sgn ? y_neg[COORD_WIDTH-1:0] : coord_y_i[COORD_WIDTH-1:0];

  assign sq_x_o = SQ_W'(ax) * SQ_W'(ax);
  assign sq_y_o = SQ_W'(ay) * SQ_W'(ay);

  assign px_rot = x_sgn ? x_neg : x_ext;
  assign py_rot = x_sgn ? y_neg : y_ext;
  assign px_o   = px_rot;
  assign py_o   = py_rot;

  always_comb begin
    ctl_o = '0;
    priority if (x_zero && y_zero) begin
      ctl_o.special = 1'b1;
      ctl_o.quad    = QUAD_0;
    end else if (x_zero) begin
      ctl_o.special = 1'b1;
      ctl_o.quad    = y_sgn ? QUAD_3 : QUAD_1;
    end else if (y_zero) begin
      ctl_o.special = 1'b1;
      ctl_o.quad    = x_sgn ? QUAD_2 : QUAD_0;
    end else begin
      ctl_o.base  = x_sgn;
      ctl_o.upper = !py_rot[COORD_WIDTH];
    end
  end

endmodule

// ===== rtl/cp_fifo.sv =====
// ----------------------------------------------------------------------------
// cp_fifo
// Short register queue between the classifier and the rotation pipeline.
// ----------------------------------------------------------------------------
`include "cartesian_to_polar_assert.svh"

module cp_fifo import cp_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CP_NEVER(a_fifo_overflow, push_i && full_o, "request pushed into full queue")
  `CP_NEVER(a_fifo_underflow, pop_i && empty_o, "request popped from empty queue")
  `CP_ASSERT(a_fifo_count, push_i && !pop_i |=> count_q == $past(count_q) + 1'b1, "bad count")

endmodule

// ===== rtl/cp_stage.sv =====
// ----------------------------------------------------------------------------
// cp_stage
// One pipeline stage: one CORDIC vectoring micro-rotation and one digit of
// the restoring square root, each present only where the stage index needs it.
// ----------------------------------------------------------------------------
module cp_stage import cp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ITERATIONS  = ITERATIONS_DEF,
  parameter int unsigned STAGE       = 0
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    adv_i,
  input  logic                                    valid_i,
  input  cp_ctl_t                                 ctl_i,
  input  logic signed [COORD_WIDTH+COORD_FRAC+CORDIC_HEADROOM-1:0] cx_i,
  input  logic signed [COORD_WIDTH+COORD_FRAC+CORDIC_HEADROOM-1:0] cy_i,
  input  logic signed [ACC_W-1:0]                 acc_i,
  input  logic [2*COORD_WIDTH-1:0]                rad_i,
  input  logic [COORD_WIDTH+1:0]                  rem_i,
  input  logic [COORD_WIDTH-1:0]                  root_i,
  output logic                                    valid_o,
  output cp_ctl_t                                 ctl_o,
  output logic signed [COORD_WIDTH+COORD_FRAC+CORDIC_HEADROOM-1:0] cx_o,
  output logic signed [COORD_WIDTH+COORD_FRAC+CORDIC_HEADROOM-1:0] cy_o,
  output logic signed [ACC_W-1:0]                 acc_o,
  output logic [2*COORD_WIDTH-1:0]                rad_o,
  output logic [COORD_WIDTH+1:0]                  rem_o,
  output logic [COORD_WIDTH-1:0]                  root_o
);

  localparam int unsigned CW   = COORD_WIDTH + COORD_FRAC + CORDIC_HEADROOM;
  localparam int unsigned SQ_W = 2 * COORD_WIDTH;
  localparam int unsigned RW   = COORD_WIDTH + 2;
  localparam bit DO_CORDIC = (STAGE < ITERATIONS);
  localparam bit DO_ROOT   = (STAGE < COORD_WIDTH);
  localparam logic signed [ACC_W-1:0] ATAN_STEP = cp_atan(STAGE);

  logic signed [CW-1:0]    dx, dy, cx_d, cy_d;
  logic signed [ACC_W-1:0] acc_d;
  logic [RW-1:0]           rem_sh, trial, rem_d;
  logic [SQ_W-1:0]         rad_d;
  logic [COORD_WIDTH-1:0]  root_d;
  logic                    ge;

  assign dx = cy_i >>> STAGE;
  assign dy = cx_i >>> STAGE;

  always_comb begin
    cx_d  = cx_i;
    cy_d  = cy_i;
    acc_d = acc_i;
    if (DO_CORDIC) begin
      if (!cy_i[CW-1]) begin
        cx_d  = cx_i + dx;
        cy_d  = cy_i - dy;
        acc_d = acc_i + ATAN_STEP;
      end else begin
        cx_d  = cx_i - dx;
        cy_d  = cy_i + dy;
        acc_d = acc_i - ATAN_STEP;
      end
    end
  end

  // two radicand bits per stage, remainder never exceeds 2 * root
  assign rem_sh = {rem_i[COORD_WIDTH-1:0], rad_i[SQ_W-1 -: 2]};
  assign trial  = {root_i, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_comb begin
    rem_d  = rem_i;
    root_d = root_i;
    rad_d  = rad_i;
    if (DO_ROOT) begin
      rem_d  = ge ? rem_sh - trial : rem_sh;
      root_d = {root_i[COORD_WIDTH-2:0], ge};
      rad_d  = {rad_i[SQ_W-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (adv_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ctl_o  <= ctl_i;
      cx_o   <= cx_d;
      cy_o   <= cy_d;
      acc_o  <= acc_d;
      rad_o  <= rad_d;
      rem_o  <= rem_d;
      root_o <= root_d;
    end
  end

endmodule

// ===== rtl/cp_back.sv =====
// ----------------------------------------------------------------------------
// cp_back
// Rotation and square-root pipeline: entry register, one stage per
// iteration or root digit, then the quadrant clamp into the output register.
// ----------------------------------------------------------------------------
`include "cartesian_to_polar_assert.svh"

module cp_back import cp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int unsigned ITERATIONS  = ITERATIONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          head_valid_i,
  input  cp_ctl_t                       head_ctl_i,
  input  logic signed [COORD_WIDTH:0]   head_px_i,
  input  logic signed [COORD_WIDTH:0]   head_py_i,
  input  logic [2*COORD_WIDTH-1:0]      head_sq_x_i,
  input  logic [2*COORD_WIDTH-1:0]      head_sq_y_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_WIDTH-1:0]        magnitude_o,
  output logic [ANGLE_WIDTH-1:0]        angle_turns_o
);

  localparam int unsigned CW   = COORD_WIDTH + COORD_FRAC + CORDIC_HEADROOM;
  localparam int unsigned SQ_W = 2 * COORD_WIDTH;
  localparam int unsigned RW   = COORD_WIDTH + 2;
  localparam int unsigned NST  = (ITERATIONS > COORD_WIDTH) ? ITERATIONS : COORD_WIDTH;

  wire                          st_v    [0:NST];
  wire cp_ctl_t                 st_ctl  [0:NST];
  wire logic signed [CW-1:0]    st_cx   [0:NST];
  wire logic signed [CW-1:0]    st_cy   [0:NST];
  wire logic signed [ACC_W-1:0] st_acc  [0:NST];
  wire logic [SQ_W-1:0]         st_rad  [0:NST];
  wire logic [RW-1:0]           st_rem  [0:NST];
  wire logic [COORD_WIDTH-1:0]  st_root [0:NST];

  logic                   adv;
  logic                   e_valid_q;
  cp_ctl_t                e_ctl_q;
  logic signed [CW-1:0]   e_cx_q, e_cy_q;
  logic [SQ_W-1:0]        e_rad_q;

  logic                   out_valid_q;
  logic [COORD_WIDTH-1:0] mag_q;
  logic [ANGLE_WIDTH-1:0] ang_q, ang_d;
  logic signed [ACC_W-1:0] acc_fin, acc_clamp;
  logic [ACC_W-1:0]       turn;

  // whole pipeline moves unless the output holds a result nobody takes
  assign adv   = !out_valid_q || out_ready_i;
  assign pop_o = adv && head_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q <= 1'b0;
    end else if (adv) begin
      e_valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_ctl_q <= head_ctl_i;
      e_cx_q  <= CW'(head_px_i) <<< COORD_FRAC;
      e_cy_q  <= CW'(head_py_i) <<< COORD_FRAC;
      e_rad_q <= head_sq_x_i + head_sq_y_i;
    end
  end

  assign st_v[0]    = e_valid_q;
  assign st_ctl[0]  = e_ctl_q;
  assign st_cx[0]   = e_cx_q;
  assign st_cy[0]   = e_cy_q;
  assign st_acc[0]  = '0;
  assign st_rad[0]  = e_rad_q;
  assign st_rem[0]  = '0;
  assign st_root[0] = '0;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    cp_stage #(
      .COORD_WIDTH (COORD_WIDTH),
      .ITERATIONS  (ITERATIONS),
      .STAGE       (k)
    ) u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (st_v[k]),
      .ctl_i   (st_ctl[k]),
      .cx_i    (st_cx[k]),
      .cy_i    (st_cy[k]),
      .acc_i   (st_acc[k]),
      .rad_i   (st_rad[k]),
      .rem_i   (st_rem[k]),
      .root_i  (st_root[k]),
      .valid_o (st_v[k+1]),
      .ctl_o   (st_ctl[k+1]),
      .cx_o    (st_cx[k+1]),
      .cy_o    (st_cy[k+1]),
      .acc_o   (st_acc[k+1]),
      .rad_o   (st_rad[k+1]),
      .rem_o   (st_rem[k+1]),
      .root_o  (st_root[k+1])
    );
  end

  // keep the residual inside the open quadrant of the rotated point
  assign acc_fin = st_acc[NST];

  always_comb begin
    acc_clamp = acc_fin;
    if (st_ctl[NST].upper) begin
      if (acc_fin[ACC_W-1]) begin
        acc_clamp = '0;
      end else if (acc_fin > QUARTER_M1) begin
        acc_clamp = QUARTER_M1;
      end
    end else begin
      if (!acc_fin[ACC_W-1]) begin
        acc_clamp = ACC_MINUS_ONE;
      end else if (acc_fin < NEG_QUARTER_M1) begin
        acc_clamp = NEG_QUARTER_M1;
      end
    end
    if (st_ctl[NST].special) begin
      turn = {st_ctl[NST].quad, {(ACC_W-2){1'b0}}};
    end else begin
      turn = (st_ctl[NST].base ? HALF_TURN : '0) + $unsigned(acc_clamp);
    end
    ang_d = turn[ACC_W-1 -: ANGLE_WIDTH];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= st_v[NST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q <= st_root[NST];
      ang_q <= ang_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign magnitude_o   = mag_q;
  assign angle_turns_o = ang_q;

  `CP_NEVER(a_pop_on_stall, pop_o && out_valid_o && !out_ready_i, "pop while output stalled")
  `CP_ASSERT(a_stall_keeps_tail, out_valid_o && !out_ready_i |=> out_valid_o, "result lost")
  `CP_ASSERT(a_stall_keeps_data, out_valid_o && !out_ready_i |=> $stable({mag_q, ang_q}), "data moved")

endmodule

// ===== rtl/cartesian_to_polar.sv =====
// ----------------------------------------------------------------------------
// cartesian_to_polar
// Rectangular to polar conversion: truncated integer magnitude and angle as
// a fraction of a full turn, via a pipelined CORDIC vectoring chain and a
// pipelined restoring square root.
//
//   channel  signals                               direction
//   in       in_valid_i/in_ready_o, coord_x_i/y_i   request in
//   out      out_valid_o/out_ready_i, magnitude_o,  result out
//            angle_turns_o
//
// One point per cycle sustained while the output is not stalled. A point
// passes the queue write, the entry register, one stage per rotation /
// root digit and the output register.
// Reset empties the queue and clears all pipeline valid bits.
// An output stall freezes the whole pipeline; the four-entry queue keeps
// taking requests until it fills, then in_ready_o drops.
// ----------------------------------------------------------------------------
module cartesian_to_polar import cp_pkg::*; #(
  parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_WIDTH = ANGLE_WIDTH_DEF,
  parameter int unsigned ITERATIONS  = ITERATIONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] coord_x_i,
  input  logic signed [COORD_WIDTH-1:0] coord_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_WIDTH-1:0]        magnitude_o,
  output logic [ANGLE_WIDTH-1:0]        angle_turns_o
);

  localparam int unsigned SQ_W = 2 * COORD_WIDTH;
  localparam int unsigned DW   = $bits(cp_ctl_t) + 2 * (COORD_WIDTH + 1) + 2 * SQ_W;

  cp_ctl_t                     f_ctl, h_ctl;
  logic signed [COORD_WIDTH:0] f_px, f_py, h_px, h_py;
  logic [SQ_W-1:0]             f_sq_x, f_sq_y, h_sq_x, h_sq_y;
  logic [DW-1:0]               q_wdata, q_rdata;
  logic                        q_full, q_empty, q_pop, q_push;

  cp_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .coord_x_i (coord_x_i),
    .coord_y_i (coord_y_i),
    .ctl_o     (f_ctl),
    .px_o      (f_px),
    .py_o      (f_py),
    .sq_x_o    (f_sq_x),
    .sq_y_o    (f_sq_y)
  );

  assign in_ready_o = !q_full;
  assign q_push     = in_valid_i && !q_full;
  assign q_wdata    = {f_ctl, f_px, f_py, f_sq_x, f_sq_y};

  cp_fifo #(
    .WIDTH (DW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  assign {h_ctl, h_px, h_py, h_sq_x, h_sq_y} = q_rdata;

  cp_back #(
    .COORD_WIDTH (COORD_WIDTH),
    .ANGLE_WIDTH (ANGLE_WIDTH),
    .ITERATIONS  (ITERATIONS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (!q_empty),
    .head_ctl_i    (h_ctl),
    .head_px_i     (h_px),
    .head_py_i     (h_py),
    .head_sq_x_i   (h_sq_x),
    .head_sq_y_i   (h_sq_y),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .magnitude_o   (magnitude_o),
    .angle_turns_o (angle_turns_o)
  );

endmodule

// ===== bench/cartesian_to_polar_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cartesian_to_polar_test
// Self-checking bench for the polar converter. Points are sent through the
// valid/ready request channel. Idling and stalls change from phase to phase,
// and one long output hold-off fills the block and stalls its input. Each
// result is checked in order against a bit-exact integer square root and
// CORDIC angle predictor.
// ----------------------------------------------------------------------------
module cartesian_to_polar_test import cp_pkg::*; ();

  localparam int unsigned COORD_W     = COORD_WIDTH_DEF;
  localparam int unsigned ANGLE_W     = ANGLE_WIDTH_DEF;
  localparam int unsigned STAGES      = ITERATIONS_DEF;
  localparam int unsigned PHASE_ITEMS = 457;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned MAX_REPORTS = 10;

  localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
  localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;
  localparam longint      QUARTER_LIMIT      = 64'sh3FFF_FFFF;

  typedef struct {
    logic [COORD_W-1:0] magnitude;
    logic [ANGLE_W-1:0] angle;
  } polar_t;

  class polar_scoreboard;
    polar_t      expected_polar[$];
    int unsigned mismatches;

    function logic [COORD_W-1:0] isqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'h1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= root + bitv) begin
          n -= root + bitv;
          root = (root >> 1) + bitv;
        end else begin
          root >>= 1;
        end
        bitv >>= 2;
      end
      return root[COORD_W-1:0];
    endfunction

    // round(atan(2^-i) / 2pi * 2^32)
    function longint rotation_angle(int unsigned i);
      case (i)
        0:       return 64'h2000_0000;
        1:       return 64'h12E4_051E;
        2:       return 64'h09FB_385B;
        3:       return 64'h0511_11D4;
        4:       return 64'h028B_0D43;
        5:       return 64'h0145_D7E1;
        6:       return 64'h00A2_F61E;
        7:       return 64'h0051_7C55;
        8:       return 64'h0028_BE53;
        9:       return 64'h0014_5F2F;
        10:      return 64'h000A_2F98;
        11:      return 64'h0005_17CC;
        12:      return 64'h0002_8BE6;
        13:      return 64'h0001_45F3;
        14:      return 64'h0000_A2FA;
        15:      return 64'h0000_517D;
        16:      return 64'h0000_28BE;
        17:      return 64'h0000_145F;
        18:      return 64'h0000_0A30;
        19:      return 64'h0000_0518;
        20:      return 64'h0000_028C;
        21:      return 64'h0000_0146;
        22:      return 64'h0000_00A3;
        23:      return 64'h0000_0051;
        24:      return 64'h0000_0029;
        25:      return 64'h0000_0014;
        26:      return 64'h0000_000A;
        27:      return 64'h0000_0005;
        28:      return 64'h0000_0003;
        29:      return 64'h0000_0001;
        30:      return 64'h0000_0001;
        default: return 64'h0;
      endcase
    endfunction

    // vectoring chain in the right half plane, angle in 2^-32 turn
    function logic [31:0] cordic_turns(longint x, longint y);
      longint      cx, cy, dx, dy, acc;
      logic [31:0] base;
      bit          upper;
      base = '0;
      acc  = 0;
      if (x < 0) begin
        x    = -x;
        y    = -y;
        base = HALF_TURN;
      end
      upper = (y > 0);
      cx = x * 65536;
      cy = y * 65536;
      for (int unsigned i = 0; i < STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx  += dx;
          cy  -= dy;
          acc += rotation_angle(i);
        end else begin
          cx  -= dx;
          cy  += dy;
          acc -= rotation_angle(i);
        end
      end
      // keep the residual inside the open quadrant of the point
      if (upper) begin
        if (acc < 0) acc = 0;
        if (acc > QUARTER_LIMIT) acc = QUARTER_LIMIT;
      end else begin
        if (acc > -1) acc = -1;
        if (acc < -QUARTER_LIMIT) acc = -QUARTER_LIMIT;
      end
      return base + acc[31:0];
    endfunction

    function void note_point(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y);
      longint          sx, sy;
      longint unsigned ax, ay;
      logic [31:0]     turns;
      polar_t          p;
      sx = x;
      sy = y;
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      p.magnitude = isqrt(ax * ax + ay * ay);
      if (sx == 0 && sy == 0) turns = '0;
      else if (sx == 0) turns = (sy > 0) ? QUARTER_TURN : THREE_QUARTER_TURN;
      else if (sy == 0) turns = (sx > 0) ? 32'h0 : HALF_TURN;
      else turns = cordic_turns(sx, sy);
      p.angle = turns[31 -: ANGLE_W];
      expected_polar.push_back(p);
    endfunction

    function void check_result(logic [COORD_W-1:0] mag, logic [ANGLE_W-1:0] ang);
      polar_t p;
      if (expected_polar.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result mag=%0d angle=%0d", $realtime, mag, ang);
        return;
      end
      p = expected_polar.pop_front();
      if (mag !== p.magnitude) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: magnitude exp %0d got %0d", $realtime, p.magnitude, mag);
      end
      if (ang !== p.angle) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: angle exp %0d got %0d", $realtime, p.angle, ang);
      end
    endfunction

    function int unsigned pending();
      return expected_polar.size();
    endfunction
  endclass

  logic                      clk_i       = 1'b0;
  logic                      rst_ni      = 1'b0;
  logic                      in_valid_i  = 1'b0;
  logic                      in_ready_o;
  logic signed [COORD_W-1:0] coord_x_i   = '0;
  logic signed [COORD_W-1:0] coord_y_i   = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  logic [COORD_W-1:0]        magnitude_o;
  logic [ANGLE_W-1:0]        angle_turns_o;

  polar_scoreboard sb = new();
  int unsigned     send_idle_pct = 0;
  int unsigned     stall_pct     = 0;
  bit              long_hold     = 1'b0;

  cartesian_to_polar uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coord_x_i     (coord_x_i),
    .coord_y_i     (coord_y_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .magnitude_o   (magnitude_o),
    .angle_turns_o (angle_turns_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // idle cycles first, then hold the request until the block takes it
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i  <= x;
    coord_y_i  <= y;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_point(x, y);
  endtask

  initial begin : receiver
    int unsigned held;
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        long_hold = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_result(magnitude_o, angle_turns_o);
  end

  initial begin : stimulus
    logic signed [COORD_W-1:0] corner_x[23];
    logic signed [COORD_W-1:0] corner_y[23];
    logic signed [COORD_W-1:0] edge_vals[6];
    logic signed [COORD_W-1:0] x, y;
    corner_x = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, 32767, -32768, 32767,
                 -32768, 1, -1, -1, 1, 32767, 32767, -32768, -32768, 3, -5};
    corner_y = '{0, 1, -1, 32767, -32768, 0, 0, 0, 0, 32767, -32768, -32768,
                 32767, 1, 1, -1, -1, 1, -1, 1, -1, 4, 12};
    edge_vals = '{-32768, 32767, -1, 1, 0, -32767};

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // axes, origin, corners and points just off the x axis
    foreach (corner_x[i]) send_point(corner_x[i], corner_y[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  long_hold = 1'b1; end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 14; stall_pct = 14; end
      endcase
      repeat (PHASE_ITEMS) begin
        case ($urandom_range(9))
          5: begin
            x = COORD_W'($urandom_range(16) - 8);
            y = COORD_W'($urandom_range(16) - 8);
          end
          6: begin
            if ($urandom_range(1)) begin x = '0; y = COORD_W'($urandom); end
            else begin x = COORD_W'($urandom); y = '0; end
          end
          7: begin
            x = edge_vals[$urandom_range(5)];
            y = edge_vals[$urandom_range(5)];
          end
          8: begin
            // close to an axis, where the quadrant clamp matters
            x = COORD_W'($urandom);
            y = COORD_W'($urandom_range(6) - 3);
            if ($urandom_range(1)) {x, y} = {y, x};
          end
          9: begin
            x = COORD_W'($urandom);
            y = $urandom_range(1) ? x : -x;
          end
          default: begin
            x = COORD_W'($urandom);
            y = COORD_W'($urandom);
          end
        endcase
        send_point(x, y);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== cartesian_to_polar.f =====
+incdir+rtl
rtl/cp_pkg.sv
rtl/cp_front.sv
rtl/cp_fifo.sv
rtl/cp_stage.sv
rtl/cp_back.sv
rtl/cartesian_to_polar.sv
bench/cartesian_to_polar_test.sv
